@@ design/cls_pkg.sv @@
`timescale 1ns / 1ps

package cls_pkg;

   localparam int NEEDLE_MAX    = 64;
   localparam int NEEDLE_ADDR_W = $clog2(NEEDLE_MAX);
   localparam int OFFSET_W      = $clog2(NEEDLE_MAX + 2);
   localparam int INDEX_WIDTH   = 16;

   localparam logic [7:0]             COMMA_BYTE = 8'h2C;
   localparam logic [INDEX_WIDTH-1:0] INDEX_TOP  = {INDEX_WIDTH{1'b1}};
   localparam logic [OFFSET_W-1:0]    OFFSET_TOP = OFFSET_W'(NEEDLE_MAX + 1);
   localparam logic [OFFSET_W-1:0]    LEN_TOP    = OFFSET_W'(NEEDLE_MAX);

   typedef enum logic {
      REQ_NEEDLE = 1'b0,
      REQ_LIST   = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                     wr_en;
      logic [NEEDLE_ADDR_W-1:0] wr_addr;
      logic [7:0]               wr_data;
      logic [NEEDLE_ADDR_W-1:0] rd_addr;
   } ram_ctrl_type;

endpackage

@@ design/cls_req_if.sv @@
`timescale 1ns / 1ps

interface cls_req_if;
   import cls_pkg::*;

   logic         valid;
   logic         ready;
   req_kind_type req_type;
   logic [7:0]   byte_value;
   logic         has_byte;
   logic         is_last;

   modport source (output valid, req_type, byte_value, has_byte, is_last, input ready);
   modport sink   (input valid, req_type, byte_value, has_byte, is_last, output ready);
endinterface

@@ design/cls_rsp_if.sv @@
`timescale 1ns / 1ps

interface cls_rsp_if;
   import cls_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [INDEX_WIDTH-1:0] position;
   logic                   needle_overflow;

   modport source (output valid, position, needle_overflow, input ready);
   modport sink   (input valid, position, needle_overflow, output ready);
endinterface

@@ design/cls_needle_ram.sv @@
`timescale 1ns / 1ps

module cls_needle_ram (
   input  logic                  clock,
   input  cls_pkg::ram_ctrl_type ctrl,
   output logic [7:0]            rd_data
);
   import cls_pkg::*;

   logic [7:0] mem [NEEDLE_MAX];

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
   end

   // write-through on address collision so the read register never goes stale
   always_ff @(posedge clock) begin
      if (ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr)) begin
         rd_data <= ctrl.wr_data;
      end else begin
         rd_data <= mem[ctrl.rd_addr];
      end
   end

endmodule

@@ design/comma_list_token_match.sv @@
`timescale 1ns / 1ps

// Finds a needle in a comma-separated list. Per row, send the needle bytes
// (req_type 0), then the list bytes (req_type 1); the list item with is_last
// set closes the row and yields one item on rsp_ch: the 1-based index of the
// first token equal to the needle, or 0 when nothing matches, the needle holds
// a comma, or the needle overran its 64-byte store (needle_overflow set).
// One item is taken every cycle; the needle byte for the next compare is
// prefetched from the needle RAM into a read register during the previous
// item. A result sits in an output register; input stalls only while that
// register is full and not being drained.
module comma_list_token_match (
   input  logic      clock,
   input  logic      reset,
   cls_req_if.sink   req_ch,
   cls_rsp_if.source rsp_ch
);
   import cls_pkg::*;

   logic [OFFSET_W-1:0]    len_ff, len_in;
   logic                   has_comma_ff, has_comma_in;
   logic                   ovf_ff, ovf_in;
   logic [INDEX_WIDTH-1:0] tok_ff, tok_in;
   logic [OFFSET_W-1:0]    off_ff, off_in;
   logic                   eq_ff, eq_in;
   logic [INDEX_WIDTH-1:0] found_ff, found_in;
   logic                   prevc_ff, prevc_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_WIDTH-1:0] position_ff, position_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   accept;
   logic                   emit;
   logic [7:0]             rd_data;
   ram_ctrl_type           ram_ctrl;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   cls_needle_ram u_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .rd_data (rd_data)
   );

   always_comb begin
      logic close;
      len_in       = len_ff;
      has_comma_in = has_comma_ff;
      ovf_in       = ovf_ff;
      tok_in       = tok_ff;
      off_in       = off_ff;
      eq_in        = eq_ff;
      found_in     = found_ff;
      prevc_in     = prevc_ff;
      close        = 1'b0;
      emit         = 1'b0;
      position_in  = position_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      ram_ctrl.wr_en   = 1'b0;
      ram_ctrl.wr_addr = len_ff[NEEDLE_ADDR_W-1:0];
      ram_ctrl.wr_data = req_ch.byte_value;

      if (accept) begin
         unique case (req_ch.req_type)
            REQ_NEEDLE: begin
               if (req_ch.has_byte) begin
                  if (req_ch.byte_value == COMMA_BYTE) begin
                     has_comma_in = 1'b1;
                  end
                  if (len_ff < LEN_TOP) begin
                     ram_ctrl.wr_en = 1'b1;
                     len_in         = len_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
            REQ_LIST: begin
               if (req_ch.has_byte) begin
                  if (req_ch.byte_value == COMMA_BYTE) begin
                     close    = 1'b1;
                     prevc_in = 1'b1;
                  end else begin
                     if (!((off_ff < len_ff) && (rd_data == req_ch.byte_value))) begin
                        eq_in = 1'b0;
                     end
                     if (off_ff < OFFSET_TOP) begin
                        off_in = off_ff + 1'b1;
                     end
                     prevc_in = 1'b0;
                  end
               end
               if (req_ch.is_last && !prevc_in) begin
                  close = 1'b1;
               end
               if (close) begin
                  if ((found_ff == '0) && eq_in && (off_in == len_ff)) begin
                     found_in = tok_ff;
                  end
                  if (tok_ff < INDEX_TOP) begin
                     tok_in = tok_ff + 1'b1;
                  end
                  off_in = '0;
                  eq_in  = 1'b1;
               end
               if (req_ch.is_last) begin
                  emit         = 1'b1;
                  position_in  = (has_comma_ff || ovf_ff) ? '0 : found_in;
                  rsp_ovf_in   = ovf_ff;
                  len_in       = '0;
                  has_comma_in = 1'b0;
                  ovf_in       = 1'b0;
                  tok_in       = INDEX_WIDTH'(1);
                  off_in       = '0;
                  eq_in        = 1'b1;
                  found_in     = '0;
                  prevc_in     = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      ram_ctrl.rd_addr = off_in[NEEDLE_ADDR_W-1:0];
      rsp_valid_in     = emit || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         has_comma_ff <= 1'b0;
         ovf_ff       <= 1'b0;
         tok_ff       <= INDEX_WIDTH'(1);
         off_ff       <= '0;
         eq_ff        <= 1'b1;
         found_ff     <= '0;
         prevc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         has_comma_ff <= has_comma_in;
         ovf_ff       <= ovf_in;
         tok_ff       <= tok_in;
         off_ff       <= off_in;
         eq_ff        <= eq_in;
         found_ff     <= found_in;
         prevc_ff     <= prevc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         position_ff <= position_in;
         rsp_ovf_ff  <= rsp_ovf_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.position        = position_ff;
   assign rsp_ch.needle_overflow = rsp_ovf_ff;

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> position_ff == '0)
      else $error("overflow result with nonzero position");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_TOP && off_ff <= OFFSET_TOP)
      else $error("needle length or token offset out of range");

   a_found_bound: assert property (@(posedge clock) disable iff (reset)
      found_ff <= tok_ff)
      else $error("found token beyond current token");

   a_row_end: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.req_type == REQ_LIST && req_ch.is_last
      |=> rsp_valid_ff && len_ff == '0 && tok_ff == INDEX_WIDTH'(1) && found_ff == '0)
      else $error("row end did not emit a result or clear state");

endmodule
